[rtl/sqrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrm_pkg
// Shared types, codes and constants for the sorted remove-min queue.
// ----------------------------------------------------------------------------
package sqrm_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int SIZE_W = 16;
    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_REMOVE
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // latch request word, prime the scan
        logic insert;       // shift-in the new entry
        logic reject;       // full, drop the insert
        logic empty_reply;  // remove on empty queue
        logic scan_step;    // advance the tie scan by one entry
        logic remove;       // take out best entry and close up the gap
    } sqrm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_more;
    } sqrm_stat_t;

endpackage

[rtl/sorted_queue_remove_min_tiebreak_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_queue_remove_min_tiebreak_core
// Bounded size-sorted queue; remove-min breaks size ties on least time.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; its single
// result word appears for one cycle with done high and must be captured then,
// as there is no way to hold it. An insert runs through S_INSERT alone. A
// remove runs a tie scan over the k held entries that share the smallest
// size: it reads one entry a cycle through the entry row's single read port
// before the row closes up. A remove on an empty queue replies from S_REMOVE
// without a scan.
// busy is low again in the cycle that shows done, so the next word may be
// issued alongside the result.
// ----------------------------------------------------------------------------
module sorted_queue_remove_min_tiebreak_core
    import sqrm_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [SIZE_W-1:0] item_size,
    input  logic [TIME_W-1:0] item_time,
    input  logic [TAG_W-1:0]  item_tag,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [SIZE_W-1:0] removed_size,
    output logic [TIME_W-1:0] removed_time,
    output logic [TAG_W-1:0]  removed_tag,
    output logic [OCC_W-1:0]  occupancy
);

    sqrm_cmd_t  cmd;
    sqrm_stat_t stat;

    sqrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    sqrm_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_size    (item_size),
        .item_time    (item_time),
        .item_tag     (item_tag),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .removed_size (removed_size),
        .removed_time (removed_time),
        .removed_tag  (removed_tag),
        .occupancy    (occupancy)
    );

endmodule

[rtl/sqrm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrm_ctrl
// Request sequencer: accepts a word, runs an insert or a remove scan.
// ----------------------------------------------------------------------------
module sqrm_ctrl
    import sqrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       req_type,
    input  sqrm_stat_t stat,
    output logic       busy,
    output sqrm_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == REQ_REMOVE) ? S_REMOVE : S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next = S_IDLE;
            end
            S_REMOVE:
            begin
                if (stat.empty || !stat.scan_more)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_INSERT:
            begin
                cmd.insert = !stat.full;
                cmd.reject = stat.full;
            end
            S_REMOVE:
            begin
                cmd.empty_reply = stat.empty;
                cmd.scan_step   = !stat.empty && stat.scan_more;
                cmd.remove      = !stat.empty && !stat.scan_more;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[rtl/sqrm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrm_datapath
// Sorted entry row with parallel shift-in / close-up, tie scan and result
// registers.
// ----------------------------------------------------------------------------
module sqrm_datapath
    import sqrm_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sqrm_cmd_t         cmd,
    input  logic [SIZE_W-1:0] item_size,
    input  logic [TIME_W-1:0] item_time,
    input  logic [TAG_W-1:0]  item_tag,
    output sqrm_stat_t        stat,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [SIZE_W-1:0] removed_size,
    output logic [TIME_W-1:0] removed_time,
    output logic [TAG_W-1:0]  removed_tag,
    output logic [OCC_W-1:0]  occupancy
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // entry row, sorted by size, index 0 at the head
    logic [SIZE_W-1:0] size_reg [QUEUE_DEPTH];
    logic [SIZE_W-1:0] size_next[QUEUE_DEPTH];
    logic [TIME_W-1:0] time_reg [QUEUE_DEPTH];
    logic [TIME_W-1:0] time_next[QUEUE_DEPTH];
    logic [TAG_W-1:0]  tag_reg  [QUEUE_DEPTH];
    logic [TAG_W-1:0]  tag_next [QUEUE_DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;

    logic [SIZE_W-1:0] req_size_reg, req_size_next;
    logic [TIME_W-1:0] req_time_reg, req_time_next;
    logic [TAG_W-1:0]  req_tag_reg,  req_tag_next;

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [TIME_W-1:0] best_time_reg, best_time_next;
    logic [TAG_W-1:0]  best_tag_reg, best_tag_next;

    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [SIZE_W-1:0] rsize_reg, rsize_next;
    logic [TIME_W-1:0] rtime_reg, rtime_next;
    logic [TAG_W-1:0]  rtag_reg, rtag_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic [QUEUE_DEPTH-1:0] gt;
    logic [IDX_W-1:0]       idx_sel;

    assign idx_sel = idx_reg[IDX_W-1:0];

    // empty slots count as larger, so the first "greater" cell is the insert point
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            gt[i] = (CNT_W'(i) >= count_reg) || (size_reg[i] > req_size_reg);
        end
    end

    always_comb
    begin
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.scan_more = (idx_reg < count_reg) && (size_reg[idx_sel] == size_reg[0]);
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            size_next[i] = size_reg[i];
            time_next[i] = time_reg[i];
            tag_next[i]  = tag_reg[i];
        end
        count_next     = count_reg;
        req_size_next  = req_size_reg;
        req_time_next  = req_time_reg;
        req_tag_next   = req_tag_reg;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        best_time_next = best_time_reg;
        best_tag_next  = best_tag_reg;

        done_next   = 1'b0;
        status_next = status_reg;
        rsize_next  = rsize_reg;
        rtime_next  = rtime_reg;
        rtag_next   = rtag_reg;
        occ_next    = occ_reg;

        if (cmd.load)
        begin
            req_size_next  = item_size;
            req_time_next  = item_time;
            req_tag_next   = item_tag;
            idx_next       = CNT_W'(1);
            best_idx_next  = '0;
            best_time_next = time_reg[0];
            best_tag_next  = tag_reg[0];
        end

        if (cmd.insert)
        begin
            if (gt[0])
            begin
                size_next[0] = req_size_reg;
                time_next[0] = req_time_reg;
                tag_next[0]  = req_tag_reg;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (gt[i-1])
                begin
                    size_next[i] = size_reg[i-1];
                    time_next[i] = time_reg[i-1];
                    tag_next[i]  = tag_reg[i-1];
                end
                else if (gt[i])
                begin
                    size_next[i] = req_size_reg;
                    time_next[i] = req_time_reg;
                    tag_next[i]  = req_tag_reg;
                end
            end
            count_next = count_reg + CNT_W'(1);
        end

        // strict compare keeps the earliest entry among equal times
        if (cmd.scan_step)
        begin
            if (time_reg[idx_sel] < best_time_reg)
            begin
                best_idx_next  = idx_sel;
                best_time_next = time_reg[idx_sel];
                best_tag_next  = tag_reg[idx_sel];
            end
            idx_next = idx_reg + CNT_W'(1);
        end

        if (cmd.remove)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (IDX_W'(i) >= best_idx_reg)
                begin
                    size_next[i] = size_reg[i+1];
                    time_next[i] = time_reg[i+1];
                    tag_next[i]  = tag_reg[i+1];
                end
            end
            count_next = count_reg - CNT_W'(1);
        end

        if (cmd.insert || cmd.reject || cmd.empty_reply || cmd.remove)
        begin
            done_next  = 1'b1;
            rsize_next = '0;
            rtime_next = '0;
            rtag_next  = '0;
            occ_next   = OCC_W'(count_next);
            if (cmd.insert)
            begin
                status_next = ST_INSERTED;
            end
            else if (cmd.reject)
            begin
                status_next = ST_FULL;
            end
            else if (cmd.empty_reply)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_REMOVED;
                rsize_next  = size_reg[0];
                rtime_next  = best_time_reg;
                rtag_next   = best_tag_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            size_reg[i] <= size_next[i];
            time_reg[i] <= time_next[i];
            tag_reg[i]  <= tag_next[i];
        end
        req_size_reg  <= req_size_next;
        req_time_reg  <= req_time_next;
        req_tag_reg   <= req_tag_next;
        idx_reg       <= idx_next;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        best_tag_reg  <= best_tag_next;
        status_reg    <= status_next;
        rsize_reg     <= rsize_next;
        rtime_reg     <= rtime_next;
        rtag_reg      <= rtag_next;
        occ_reg       <= occ_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign removed_size = rsize_reg;
    assign removed_time = rtime_reg;
    assign removed_tag  = rtag_reg;
    assign occupancy    = occ_reg;

endmodule

[rtl/sqrm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrm_checker
// Port-level checks on the queue core, bound to the top level.
// ----------------------------------------------------------------------------
module sqrm_checker
    import sqrm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [STAT_W-1:0] status,
    input logic [SIZE_W-1:0] removed_size,
    input logic [TIME_W-1:0] removed_time,
    input logic [TAG_W-1:0]  removed_tag,
    input logic [OCC_W-1:0]  occupancy
);

    // an accepted word always keeps the core busy after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // result shows exactly as the core finishes a word
    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("done without a finishing word");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("word finished without a result");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_REMOVED)
            |-> (removed_size == '0 && removed_time == '0 && removed_tag == '0))
        else $error("removed fields nonzero on non-remove result");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty reply with nonzero occupancy");

endmodule

bind sorted_queue_remove_min_tiebreak_core sqrm_checker u_sqrm_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-sorted remove-min queue core.
// ----------------------------------------------------------------------------
// A driver feeds request words from a pending list. It inserts random idle
// bursts in some stretches and none near the end. A monitor accepts
// each word and runs it through a local model of the sorted queue. It then
// compares every result word, field by field, with the oldest prediction.
// Directed words cover the field extremes, the empty queue and size/time
// ties. Random words, mostly small keys, drive the queue through full and
// empty many times.
// ----------------------------------------------------------------------------
module tb_top;
    import sqrm_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int RAND_WORDS  = 830;
    localparam int NO_IDLE_END = 150;   // words at the end sent back to back
    localparam int SETTLE      = 40;
    localparam int WATCHDOG    = 2000;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] stamp;
        logic [TAG_W-1:0]  tag;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] stamp;
        logic [TAG_W-1:0]  tag;
        logic [OCC_W-1:0]  occ;
    } reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              req_type = REQ_INSERT;
    logic [SIZE_W-1:0] item_size = '0;
    logic [TIME_W-1:0] item_time = '0;
    logic [TAG_W-1:0]  item_tag = '0;
    logic              busy;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] removed_size;
    logic [TIME_W-1:0] removed_time;
    logic [TAG_W-1:0]  removed_tag;
    logic [OCC_W-1:0]  occupancy;

    sorted_queue_remove_min_tiebreak_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .item_size    (item_size),
        .item_time    (item_time),
        .item_tag     (item_tag),
        .done         (done),
        .status       (status),
        .removed_size (removed_size),
        .removed_time (removed_time),
        .removed_tag  (removed_tag),
        .occupancy    (occupancy)
    );

    // model of the held entries, kept in ascending size order
    logic [SIZE_W-1:0] held_size [DEPTH];
    logic [TIME_W-1:0] held_stamp [DEPTH];
    logic [TAG_W-1:0]  held_tag [DEPTH];
    int                held_count = 0;

    request_t request_fifo[$];
    reply_t   due_replies[$];
    request_t next_word;

    int  total_words = 0;
    int  issued = 0;
    int  gap = 0;
    logic took = 1'b0;
    int  idle_cycles = 0;
    int  errors = 0;
    int  n_insert = 0, n_remove = 0, n_empty = 0, n_full = 0, widest_tie = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    function automatic reply_t predict_reply(input request_t w);
        reply_t r;
        int     i;
        int     pos;
        bit     found;
        r = '0;
        if (w.kind == REQ_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                // new word goes after every entry of equal or smaller size
                pos = held_count;
                found = 1'b0;
                for (i = 0; i < held_count; i++) begin
                    if (!found && held_size[i] > w.size) begin
                        pos = i;
                        found = 1'b1;
                    end
                end
                for (i = held_count; i > pos; i--) begin
                    held_size[i]  = held_size[i-1];
                    held_stamp[i] = held_stamp[i-1];
                    held_tag[i]   = held_tag[i-1];
                end
                held_size[pos]  = w.size;
                held_stamp[pos] = w.stamp;
                held_tag[pos]   = w.tag;
                held_count++;
                r.status = ST_INSERTED;
                n_insert++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
        end else begin
            // scan the run of smallest sizes, earliest wins on equal time
            pos = 0;
            i = 1;
            while (i < held_count && held_size[i] == held_size[0]) begin
                if (held_stamp[i] < held_stamp[pos])
                    pos = i;
                i++;
            end
            if (i > widest_tie)
                widest_tie = i;
            r.status = ST_REMOVED;
            r.size   = held_size[pos];
            r.stamp  = held_stamp[pos];
            r.tag    = held_tag[pos];
            for (i = pos; i + 1 < held_count; i++) begin
                held_size[i]  = held_size[i+1];
                held_stamp[i] = held_stamp[i+1];
                held_tag[i]   = held_tag[i+1];
            end
            held_count--;
            n_remove++;
        end
        r.occ = held_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic check_reply();
        reply_t e;
        if (due_replies.size() == 0) begin
            report_mismatch($sformatf("result word with none expected, status %0d", status));
        end else begin
            e = due_replies.pop_front();
            if (status !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
            if (removed_size !== e.size)
                report_mismatch($sformatf("removed_size %h, expected %h",
                                          removed_size, e.size));
            if (removed_time !== e.stamp)
                report_mismatch($sformatf("removed_time %h, expected %h",
                                          removed_time, e.stamp));
            if (removed_tag !== e.tag)
                report_mismatch($sformatf("removed_tag %h, expected %h",
                                          removed_tag, e.tag));
            if (occupancy !== e.occ)
                report_mismatch($sformatf("occupancy %0d, expected %0d",
                                          occupancy, e.occ));
        end
    endtask

    task automatic push_insert(input logic [SIZE_W-1:0] sz, input logic [TIME_W-1:0] st,
                               input logic [TAG_W-1:0] tg);
        request_fifo.push_back('{REQ_INSERT, sz, st, tg});
    endtask

    task automatic push_remove();
        // payload is don't-care on a remove; keep it random
        request_fifo.push_back('{REQ_REMOVE, 16'($urandom), $urandom, 16'($urandom)});
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return SIZE_W'($urandom_range(0, 3));
        else if (sel < 9)
            return SIZE_W'($urandom);
        else
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    function automatic logic [TIME_W-1:0] pick_stamp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return TIME_W'($urandom_range(0, 3));
        else if (sel < 9)
            return $urandom;
        else
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    // driver: changes inputs on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (gap > 0) begin
                start <= 1'b0;
                gap <= gap - 1;
            end else if (request_fifo.size() > 0) begin
                next_word = request_fifo.pop_front();
                start     <= 1'b1;
                req_type  <= next_word.kind;
                item_size <= next_word.size;
                item_time <= next_word.stamp;
                item_tag  <= next_word.tag;
                issued    <= issued + 1;
                // idle only in some stretches, never near the end
                if (issued < total_words - NO_IDLE_END && (issued / 60) % 3 != 2
                    && $urandom_range(0, 4) == 0)
                    gap <= $urandom_range(1, 15);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: samples on the rising edge
    always @(posedge clk) begin
        if (!rst_n) begin
            took <= 1'b0;
            idle_cycles <= 0;
        end else begin
            took <= start && !busy;
            if (done)
                check_reply();
            if (start && !busy)
                due_replies.push_back(predict_reply('{req_type, item_size, item_time,
                                                      item_tag}));
            if ((start && !busy) || done) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG) begin
                $display("Watchdog: no word moved for %0d cycles", WATCHDOG);
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int mode;
        int k;
        int ins_pct;

        // directed: empty queue, field extremes, size and time ties
        push_remove();
        push_insert('1, '0, '0);
        push_insert('0, '1, '1);
        push_insert('0, 32'd7, 16'd1);
        push_insert('0, 32'd7, 16'd2);
        push_insert('0, '1, 16'd3);
        push_insert(16'd1, '0, 16'd4);
        push_insert(16'd5, 32'h5555_5555, 16'hAAAA);
        push_insert(16'd3, 32'hAAAA_AAAA, 16'h5555);
        push_insert(16'd4, 32'd9, 16'd5);
        for (k = 0; k < 10; k++)
            push_remove();
        push_remove();

        // random: phases lean toward filling, draining, or neither
        for (k = 0; k < RAND_WORDS; k++) begin
            if (k % 40 == 0)
                mode = $urandom_range(0, 2);
            ins_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 50;
            if ($urandom_range(0, 99) < ins_pct)
                push_insert(pick_size(), pick_stamp(), 16'($urandom));
            else
                push_remove();
        end
        total_words = request_fifo.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_fifo.size() != 0 || start || due_replies.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d words: %0d inserts, %0d removals, %0d removes on empty,",
                 total_words, n_insert, n_remove, n_empty);
        $display("%0d inserts dropped on full; longest smallest-size tie run was %0d",
                 n_full, widest_tie);
        if (errors == 0 && due_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/sqrm_pkg.sv
rtl/sqrm_ctrl.sv
rtl/sqrm_datapath.sv
rtl/sorted_queue_remove_min_tiebreak_core.sv
rtl/sqrm_checker.sv
bench/tb_top.sv
